// File: design/htlp_pkg.sv
// package for the linear-probe hash table: widths, operation and status codes, key mixer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package htlp_pkg;
    localparam int unsigned CAPACITY_DEF = 128;
    localparam int unsigned COUNT_W = 8;

    localparam logic [1:0] OP_PUT    = 2'd0;
    localparam logic [1:0] OP_GET    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    localparam logic [31:0] MIX_MUL_A = 32'h85ebca6b;
    localparam logic [31:0] MIX_MUL_B = 32'hc2b2ae35;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] lookup_key;
        logic [31:0] write_value;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [31:0]        read_value;
        logic [COUNT_W-1:0] live_count;
    } rsp_t;
endpackage
`default_nettype wire

// File: design/htlp_if.sv
// valid/ready channel interface carrying one payload of type payload_t
// no dependencies; the payload type is a parameter
`timescale 1ns / 1ps
`default_nettype none
interface htlp_if #(parameter type payload_t = logic) (input wire logic clk);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: design/htlp_ram.sv
// generic single-port synchronous ram, registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module htlp_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// File: design/hash_table_linear_probe_top.sv
// top level of the linear-probe hash table: sequencer, slot flag ram, key/value rams
// depends on htlp_pkg, htlp_if and htlp_ram
`timescale 1ns / 1ps
`default_nettype none
// Fixed-capacity map from 32-bit keys to 32-bit values with linear probing and
// tombstones. One request at a time. The first multiply of the key mix is registered
// at acceptance; the second multiply is registered in S_MIX1 and the fold to a start
// slot in S_MIX2. Each probed slot then goes through the single-port rams in S_ADDR
// (address) and S_CMP (compare the registered read). S_WRITE writes back and S_RESP
// posts the response. Keys, values and the used/tombstone flags all live in rams
// with no reset. After reset the block walks the flag ram one slot per cycle to
// clear it, and takes no request until the walk is done. A clear request does the
// same walk and then posts its response from S_RESP. A new request is taken only in
// S_IDLE, when the response register is free or being drained.
module hash_table_linear_probe_top #(
    parameter int unsigned CAPACITY = htlp_pkg::CAPACITY_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    htlp_if.sink     req,
    htlp_if.source   rsp
);
    import htlp_pkg::*;

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned NW = AW + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MIX1  = 3'd1;
    localparam logic [2:0] S_MIX2  = 3'd2;
    localparam logic [2:0] S_ADDR  = 3'd3;
    localparam logic [2:0] S_CMP   = 3'd4;
    localparam logic [2:0] S_WRITE = 3'd5;
    localparam logic [2:0] S_RESP  = 3'd6;
    localparam logic [2:0] S_CLEAR = 3'd7;

    logic [2:0]         state_reg, state_next;
    req_t               op_reg;
    logic [31:0]        h_reg;
    logic [AW-1:0]      slot_reg;
    logic [NW-1:0]      n_reg;
    logic               tomb_seen_reg;
    logic [AW-1:0]      tomb_slot_reg;
    logic               hit_reg;
    logic               found_reg;
    logic [AW-1:0]      target_reg;
    logic [COUNT_W-1:0] entry_reg;
    logic               out_valid_reg;
    rsp_t               out_reg;

    logic               ram_we;
    logic [AW-1:0]      ram_addr;
    logic [31:0]        key_rdata;
    logic [31:0]        val_rdata;
    logic               val_we;
    logic               flag_we;
    logic [1:0]         flag_wdata;
    logic [1:0]         flag_rdata;
    logic               slot_used;
    logic               slot_tomb;
    logic [31:0]        h0;

    assign h0 = req.data.lookup_key ^ (req.data.lookup_key >> 16);

    // flag ram word: {used, tombstone}
    assign slot_used = flag_rdata[1];
    assign slot_tomb = flag_rdata[0];

    assign req.ready = (state_reg == S_IDLE) && (!out_valid_reg || rsp.ready);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    always_comb
    begin
        ram_addr   = (state_reg == S_WRITE) ? target_reg : slot_reg;
        ram_we     = (state_reg == S_WRITE) && (op_reg.kind == OP_PUT) && found_reg && !hit_reg;
        val_we     = (state_reg == S_WRITE) && (op_reg.kind == OP_PUT) && found_reg;
        flag_we    = 1'b0;
        flag_wdata = 2'b00;
        if (state_reg == S_CLEAR)
        begin
            flag_we = 1'b1;
        end
        else if (state_reg == S_WRITE)
        begin
            if ((op_reg.kind == OP_PUT) && found_reg && !hit_reg)
            begin
                flag_we    = 1'b1;
                flag_wdata = 2'b10;
            end
            else if ((op_reg.kind == OP_REMOVE) && hit_reg)
            begin
                flag_we    = 1'b1;
                flag_wdata = 2'b11;
            end
        end
    end

    htlp_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_keys (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(op_reg.lookup_key),
        .rdata(key_rdata)
    );
    htlp_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_vals (
        .clk(clk), .we(val_we), .addr(ram_addr), .wdata(op_reg.write_value),
        .rdata(val_rdata)
    );
    htlp_ram #(.WIDTH(2), .DEPTH(CAPACITY)) u_flags (
        .clk(clk), .we(flag_we), .addr(ram_addr), .wdata(flag_wdata),
        .rdata(flag_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            op_reg        <= '0;
            slot_reg      <= '0;
            n_reg         <= '0;
            entry_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid && req.ready)
                    begin
                        op_reg        <= req.data;
                        h_reg         <= h0 * MIX_MUL_A;
                        tomb_seen_reg <= 1'b0;
                        hit_reg       <= 1'b0;
                        found_reg     <= 1'b0;
                        n_reg         <= '0;
                        if (req.data.kind == OP_CLEAR)
                        begin
                            slot_reg  <= '0;
                            entry_reg <= '0;
                        end
                    end
                end
                S_CLEAR:
                begin
                    slot_reg <= slot_reg + 1'b1;
                    n_reg    <= n_reg + 1'b1;
                end
                S_MIX1:
                begin
                    h_reg <= (h_reg ^ (h_reg >> 13)) * MIX_MUL_B;
                end
                S_MIX2:
                begin
                    slot_reg <= h_reg[AW-1:0] ^ h_reg[AW+15:16];
                end
                S_CMP:
                begin
                    n_reg <= n_reg + 1'b1;
                    if (!slot_used)
                    begin
                        found_reg  <= 1'b1;
                        target_reg <= tomb_seen_reg ? tomb_slot_reg : slot_reg;
                    end
                    else if (slot_tomb)
                    begin
                        if (!tomb_seen_reg)
                        begin
                            tomb_seen_reg <= 1'b1;
                            tomb_slot_reg <= slot_reg;
                        end
                    end
                    else if (key_rdata == op_reg.lookup_key)
                    begin
                        found_reg  <= 1'b1;
                        hit_reg    <= 1'b1;
                        target_reg <= slot_reg;
                    end
                    if (n_reg == NW'(CAPACITY - 1) && slot_used
                        && !(!slot_tomb && key_rdata == op_reg.lookup_key))
                    begin
                        // walk ends without an unused slot: first tombstone, if any
                        found_reg  <= tomb_seen_reg || slot_tomb;
                        target_reg <= tomb_seen_reg ? tomb_slot_reg : slot_reg;
                    end
                    slot_reg <= slot_reg + 1'b1;
                end
                S_WRITE:
                begin
                    out_reg.status     <= ST_OK;
                    out_reg.read_value <= '0;
                    out_reg.live_count <= entry_reg;
                    case (op_reg.kind)
                        OP_PUT:
                        begin
                            if (!found_reg)
                            begin
                                out_reg.status <= ST_FULL;
                            end
                            else if (!hit_reg)
                            begin
                                entry_reg          <= entry_reg + 1'b1;
                                out_reg.live_count <= entry_reg + 1'b1;
                            end
                        end
                        OP_GET:
                        begin
                            if (hit_reg)
                            begin
                                out_reg.read_value <= val_rdata;
                            end
                            else
                            begin
                                out_reg.status <= ST_ABSENT;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (hit_reg)
                            begin
                                entry_reg          <= entry_reg - 1'b1;
                                out_reg.live_count <= entry_reg - 1'b1;
                            end
                            else
                            begin
                                out_reg.status <= ST_ABSENT;
                            end
                        end
                        default:
                        begin
                            out_reg.status <= ST_OK;
                        end
                    endcase
                end
                S_RESP:
                begin
                    if (op_reg.kind == OP_CLEAR)
                    begin
                        out_reg.status     <= ST_OK;
                        out_reg.read_value <= '0;
                        out_reg.live_count <= '0;
                    end
                    out_valid_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid && req.ready)
                begin
                    state_next = (req.data.kind == OP_CLEAR) ? S_CLEAR : S_MIX1;
                end
            end
            S_CLEAR:
            begin
                if (n_reg == NW'(CAPACITY - 1))
                begin
                    state_next = (op_reg.kind == OP_CLEAR) ? S_RESP : S_IDLE;
                end
            end
            S_MIX1:  state_next = S_MIX2;
            S_MIX2:  state_next = S_ADDR;
            S_ADDR:  state_next = S_CMP;
            S_CMP:
            begin
                if (!slot_used || n_reg == NW'(CAPACITY - 1)
                    || (!slot_tomb && key_rdata == op_reg.lookup_key))
                begin
                    state_next = S_WRITE;
                end
                else
                begin
                    state_next = S_ADDR;
                end
            end
            S_WRITE: state_next = S_RESP;
            S_RESP:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // the write-back cycle must read the value at the hit slot for a get
    a_get_reads_target: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WRITE |-> ram_addr == target_reg)
        else $error("write-back address differs from target");
    a_resp_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RESP |=> out_valid_reg)
        else $error("response not posted");
    a_no_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !req.ready)
        else $error("request taken while busy");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_reg <= COUNT_W'(CAPACITY))
        else $error("entry count overflow");
endmodule
`default_nettype wire

// File: dv/tb_top.sv
// testbench for the linear-probe hash table: random and directed put/get/remove/clear
// requests checked against a behavioral copy of the table; depends on htlp_pkg, htlp_if
`timescale 1ns / 1ps
module tb_top;
    import htlp_pkg::*;

    localparam int SLOTS = 128;

    logic clk;
    logic rst_n;

    htlp_if #(.payload_t(req_t)) req_ch (clk);
    htlp_if #(.payload_t(rsp_t)) rsp_ch (clk);

    hash_table_linear_probe_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    // behavioral copy of the table
    logic [31:0] tbl_key [SLOTS];
    logic [31:0] tbl_val [SLOTS];
    bit          tbl_used [SLOTS];
    bit          tbl_tomb [SLOTS];
    int unsigned n_live;
    int unsigned n_tomb;

    req_t pending_reqs[$];
    rsp_t expected_rsps[$];
    logic [31:0] known_keys[$];
    int  errors;
    bit  stim_done;
    int  send_wait;
    int  recv_wait;
    bit  hold_drain;

    function automatic logic [31:0] fmix(logic [31:0] k);
        logic [31:0] h;
        h = k ^ (k >> 16);
        h = h * MIX_MUL_A;
        h = h ^ (h >> 13);
        h = h * MIX_MUL_B;
        return h ^ (h >> 16);
    endfunction

    function automatic rsp_t table_apply(req_t r);
        rsp_t o;
        int   st;
        int   s;
        int   tomb_at;
        int   where;
        bit   hit;
        o = '0;
        hit = 0;
        where = -1;
        tomb_at = -1;
        if (r.kind == OP_CLEAR) begin
            for (int i = 0; i < SLOTS; i++)
            begin
                tbl_used[i] = 0;
                tbl_tomb[i] = 0;
            end
            n_live = 0;
            n_tomb = 0;
        end
        else begin
            st = int'(fmix(r.lookup_key) & (SLOTS - 1));
            for (int n = 0; n < SLOTS; n++)
            begin
                s = (st + n) & (SLOTS - 1);
                if (!tbl_used[s])
                begin
                    where = (tomb_at >= 0) ? tomb_at : s;
                    break;
                end
                if (tbl_tomb[s])
                begin
                    if (tomb_at < 0)
                        tomb_at = s;
                    continue;
                end
                if (tbl_key[s] == r.lookup_key)
                begin
                    where = s;
                    hit = 1;
                    break;
                end
            end
            // walk saw no unused slot: first tombstone, if any
            if (!hit && where < 0)
                where = tomb_at;
            if (r.kind == OP_PUT)
            begin
                if (hit)
                    tbl_val[where] = r.write_value;
                else if (where < 0)
                    o.status = ST_FULL;
                else
                begin
                    if (tbl_tomb[where] && n_tomb > 0)
                        n_tomb--;
                    tbl_key[where] = r.lookup_key;
                    tbl_val[where] = r.write_value;
                    tbl_used[where] = 1;
                    tbl_tomb[where] = 0;
                    n_live++;
                end
            end
            else if (r.kind == OP_GET)
            begin
                if (hit)
                    o.read_value = tbl_val[where];
                else
                    o.status = ST_ABSENT;
            end
            else
            begin
                if (hit)
                begin
                    tbl_tomb[where] = 1;
                    if (n_live > 0)
                        n_live--;
                    n_tomb++;
                end
                else
                    o.status = ST_ABSENT;
            end
        end
        o.live_count = n_live[COUNT_W-1:0];
        return o;
    endfunction

    function automatic logic [31:0] pick_key();
        // mostly reuse keys already seen so gets and removes hit
        if (known_keys.size() > 0 && $urandom_range(0, 3) != 0)
            return known_keys[$urandom_range(0, known_keys.size() - 1)];
        return $urandom();
    endfunction

    task automatic queue_req(logic [1:0] kind, logic [31:0] key, logic [31:0] value);
        req_t r;
        r.kind = kind;
        r.lookup_key = key;
        r.write_value = value;
        pending_reqs.push_back(r);
        if (kind == OP_PUT)
            known_keys.push_back(key);
        if (known_keys.size() > 300)
            void'(known_keys.pop_front());
    endtask

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rst_n = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
    end

    initial
    begin
        #20ms;
        $display("hash_table_linear_probe_top test failed");
        $finish;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 0;
            req_ch.data  <= '0;
            send_wait    <= 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                expected_rsps.push_back(table_apply(req_ch.data));
            if (req_ch.valid && !req_ch.ready)
                ;
            else if (send_wait > 0)
            begin
                req_ch.valid <= 0;
                send_wait <= send_wait - 1;
            end
            else if (pending_reqs.size() > 0 && !hold_drain &&
                     !(req_ch.valid && pending_reqs.size() == 0))
            begin
                req_ch.valid <= 1;
                req_ch.data  <= pending_reqs.pop_front();
                send_wait    <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            end
            else
                req_ch.valid <= 0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 0;
            recv_wait    <= 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected response %p", rsp_ch.data);
                end
                else
                begin
                    rsp_t e;
                    e = expected_rsps.pop_front();
                    if (e.status !== rsp_ch.data.status ||
                        e.read_value !== rsp_ch.data.read_value ||
                        e.live_count !== rsp_ch.data.live_count)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected %p got %p", e, rsp_ch.data);
                    end
                end
                recv_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                rsp_ch.ready <= 0;
            end
            else if (recv_wait > 0)
            begin
                recv_wait <= recv_wait - 1;
                rsp_ch.ready <= 0;
            end
            else
                rsp_ch.ready <= 1;
        end
    end

    initial
    begin
        int unsigned mode;
        int unsigned wait_cycles;
        errors = 0;
        stim_done = 0;
        hold_drain = 0;
        n_live = 0;
        n_tomb = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            tbl_used[i] = 0;
            tbl_tomb[i] = 0;
            tbl_key[i] = '0;
            tbl_val[i] = '0;
        end

        // directed: empty table, extremes, tombstone reuse, clear
        queue_req(OP_GET, 32'h0, 32'h0);
        queue_req(OP_REMOVE, 32'hffffffff, 32'h0);
        queue_req(OP_PUT, 32'h0, 32'hffffffff);
        queue_req(OP_PUT, 32'hffffffff, 32'h0);
        queue_req(OP_GET, 32'h0, 32'h12345678);
        queue_req(OP_GET, 32'hffffffff, 32'h0);
        queue_req(OP_PUT, 32'h0, 32'ha5a5a5a5);
        queue_req(OP_GET, 32'h0, 32'h0);
        queue_req(OP_REMOVE, 32'h0, 32'h0);
        queue_req(OP_GET, 32'h0, 32'h0);
        queue_req(OP_REMOVE, 32'h0, 32'h0);
        queue_req(OP_PUT, 32'h0, 32'h5a5a5a5a);
        queue_req(OP_GET, 32'h0, 32'h0);
        queue_req(OP_CLEAR, 32'hffffffff, 32'hffffffff);
        queue_req(OP_GET, 32'hffffffff, 32'h0);

        // fill to capacity, then a put into the full table, then removes and full probe through tombstones
        for (int i = 0; i < SLOTS; i++)
            queue_req(OP_PUT, $urandom(), $urandom());
        queue_req(OP_PUT, 32'hdeadbeef, 32'h1);
        queue_req(OP_GET, 32'hdeadbeef, 32'h0);
        for (int i = 0; i < 10; i++)
            queue_req(OP_REMOVE, pick_key(), 32'h0);
        queue_req(OP_GET, $urandom(), 32'h0);
        queue_req(OP_PUT, 32'hdeadbeef, 32'h2);
        queue_req(OP_GET, 32'hdeadbeef, 32'h0);

        // pause until the block has drained
        wait (pending_reqs.size() == 0);
        hold_drain = 1;
        wait (expected_rsps.size() == 0 && !req_ch.valid);
        hold_drain = 0;
        queue_req(OP_CLEAR, 32'h0, 32'h0);

        for (int i = 0; i < 1790; i++)
        begin
            mode = $urandom_range(0, 99);
            if (mode < 40)
                queue_req(OP_PUT, pick_key(), $urandom());
            else if (mode < 70)
                queue_req(OP_GET, pick_key(), $urandom());
            else if (mode < 98)
                queue_req(OP_REMOVE, pick_key(), $urandom());
            else
                queue_req(OP_CLEAR, $urandom(), $urandom());
            if (pending_reqs.size() > 50)
                wait (pending_reqs.size() < 20);
        end

        wait (pending_reqs.size() == 0);
        wait (expected_rsps.size() == 0 && !req_ch.valid);
        wait_cycles = 0;
        while (wait_cycles < 600)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        if (errors == 0 && expected_rsps.size() == 0)
            $display("hash_table_linear_probe_top test passed");
        else
            $display("hash_table_linear_probe_top test failed");
        $finish;
    end
endmodule
